@@ rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned MAX_BYTES_DEF   = 16;
  localparam int unsigned BYTE_BITS       = 8;
  localparam logic [7:0]  PHASE_TICKS_RST = 8'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd50;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUS_BUSY  = 2'd1,
    ST_ADDR_NACK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ROLE_WADDR = 2'd0,
    ROLE_REG   = 2'd1,
    ROLE_RADDR = 2'd2,
    ROLE_DATA  = 2'd3
  } role_e;

  typedef enum logic [4:0] {
    S_IDLE     = 5'd0,
    S_START_A  = 5'd1,
    S_START_B  = 5'd2,
    S_RS_PREP  = 5'd3,
    S_TX_SET   = 5'd4,
    S_TX_HIGH  = 5'd5,
    S_TX_HOLD  = 5'd6,
    S_ACK_SET  = 5'd7,
    S_ACK_WAIT = 5'd8,
    S_RX_LOW1  = 5'd9,
    S_RX_LOW2  = 5'd10,
    S_RX_HIGH1 = 5'd11,
    S_RX_HIGH2 = 5'd12,
    S_MA_SET   = 5'd13,
    S_MA_HIGH  = 5'd14,
    S_STOP_A   = 5'd15,
    S_STOP_B   = 5'd16,
    S_STOP_C   = 5'd17
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [4:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    status_e    status;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

@@ rtl/i2cm_wbuf.sv @@
`timescale 1ns / 1ps

module i2cm_wbuf #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [7:0]      wr_data_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule

@@ rtl/i2cm_seq.sv @@
`timescale 1ns / 1ps

module i2cm_seq #(
  parameter int unsigned MAX_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cm_pkg::item_t   item_i,
  input  i2cm_pkg::cfg_t    cfg_i,
  output i2cm_pkg::result_t res_o
);
  import i2cm_pkg::*;

  localparam int unsigned CntW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES + 1) : 1;
  localparam int unsigned IdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [CntW:0] MaxCnt = (CntW + 1)'(MAX_BYTES);

  state_e          state_q, state_d;
  logic [7:0]      phase_q, phase_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [CntW-1:0] done_cnt_q, done_cnt_d;
  logic [CntW-1:0] total_q, total_d;
  logic [7:0]      wait_q, wait_d;
  logic [6:0]      addr_q, addr_d;
  logic [7:0]      reg_q, reg_d;
  logic            is_read_q, is_read_d;
  logic [CntW-1:0] fill_q, fill_d;
  role_e           role_q, role_d;
  logic            fail_q, fail_d;

  logic            wr_en;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]      rd_data;

  logic            last;
  logic [CntW:0]   done_inc;
  logic [7:0]      tick_lim;
  logic            phase_run;
  logic [8:0]      wait_inc;
  logic [4:0]      bit_inc;
  logic            acked;
  logic            scl_drv, sda_drv;

  assign done_inc  = {1'b0, done_cnt_q} + 1'b1;
  assign last      = done_inc >= {1'b0, total_q};
  assign tick_lim  = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
  assign phase_run = ({1'b0, phase_q} + 9'd1) < {1'b0, tick_lim};
  assign wait_inc  = {1'b0, wait_q} + 9'd1;
  assign bit_inc   = {1'b0, bit_q} + 5'd1;
  assign acked     = !item_i.sda_sample;
  // a data byte reads the entry after the one just acknowledged
  assign rd_idx    = (role_q == ROLE_DATA) ? done_inc[IdxW-1:0] : done_cnt_q[IdxW-1:0];

  i2cm_wbuf #(
    .DEPTH(MAX_BYTES)
  ) u_wbuf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (fill_q[IdxW-1:0]),
    .wr_data_i(item_i.tx_byte),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  // line drive, from the current state, shift register and byte counters
  always_comb begin
    scl_drv = 1'b1;
    sda_drv = 1'b1;
    unique case (state_q)
      S_START_B:                        sda_drv = 1'b0;
      S_RS_PREP:                        scl_drv = 1'b0;
      S_TX_SET, S_TX_HOLD: begin
        scl_drv = 1'b0;
        sda_drv = shift_q[7];
      end
      S_TX_HIGH:                        sda_drv = shift_q[7];
      S_ACK_SET, S_RX_LOW1, S_RX_LOW2:  scl_drv = 1'b0;
      S_MA_SET: begin
        scl_drv = 1'b0;
        sda_drv = last;
      end
      S_MA_HIGH:                        sda_drv = last;
      S_STOP_A: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
      end
      S_STOP_B:                         sda_drv = 1'b0;
      default: ;
    endcase
  end

  // next state and datapath
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    done_cnt_d = done_cnt_q;
    total_d    = total_q;
    wait_d     = wait_q;
    addr_d     = addr_q;
    reg_d      = reg_q;
    is_read_d  = is_read_q;
    fill_d     = fill_q;
    role_d     = role_q;
    fail_d     = fail_q;
    wr_en      = 1'b0;
    res_o          = '0;
    res_o.status   = ST_OK;

    if (state_q == S_IDLE) begin
      priority if (item_i.op == OP_PUSH) begin
        if ({1'b0, fill_q} < MaxCnt) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 1'b1;
        end
      end else if (item_i.op == OP_WRITE || item_i.op == OP_READ) begin
        is_read_d = (item_i.op == OP_READ);
        if (!item_i.sda_sample) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_BUS_BUSY;
          if (item_i.op != OP_READ) begin
            fill_d = '0;
          end
        end else begin
          addr_d     = item_i.dev_addr;
          reg_d      = item_i.reg_addr;
          total_d    = (9'(item_i.byte_count) > 9'(MAX_BYTES)) ? CntW'(MAX_BYTES)
                                                               : CntW'(item_i.byte_count);
          done_cnt_d = '0;
          fail_d     = 1'b0;
          wait_d     = '0;
          role_d     = ROLE_WADDR;
          phase_d    = '0;
          state_d    = S_START_A;
        end
      end else begin
      end
    end else if (phase_run) begin
      phase_d = phase_q + 8'd1;
    end else begin
      phase_d = '0;
      unique case (state_q)
        S_RS_PREP: state_d = S_START_A;
        S_START_A: state_d = S_START_B;
        S_START_B: begin
          shift_d = {addr_q, role_q == ROLE_RADDR};
          bit_d   = '0;
          state_d = S_TX_SET;
        end
        S_TX_SET:  state_d = S_TX_HIGH;
        S_TX_HIGH: state_d = S_TX_HOLD;
        S_TX_HOLD: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc[3:0];
          if (bit_inc >= 5'(BYTE_BITS)) begin
            wait_d  = '0;
            state_d = S_ACK_SET;
          end else begin
            state_d = S_TX_SET;
          end
        end
        S_ACK_SET: state_d = S_ACK_WAIT;
        S_ACK_WAIT: begin
          if (!acked) begin
            wait_d = wait_inc[7:0];
          end
          if (acked || wait_inc > {1'b0, cfg_i.ack_timeout}) begin
            unique case (role_q)
              ROLE_WADDR: begin
                if (!acked) begin
                  fail_d  = 1'b1;
                  state_d = S_STOP_A;
                end else begin
                  shift_d = reg_q;
                  role_d  = ROLE_REG;
                  bit_d   = '0;
                  state_d = S_TX_SET;
                end
              end
              ROLE_REG: begin
                if (is_read_q) begin
                  role_d  = ROLE_RADDR;
                  state_d = S_RS_PREP;
                end else if (done_cnt_q < total_q && {1'b0, done_cnt_q} < MaxCnt) begin
                  shift_d = rd_data;
                  role_d  = ROLE_DATA;
                  bit_d   = '0;
                  state_d = S_TX_SET;
                end else begin
                  state_d = S_STOP_A;
                end
              end
              ROLE_RADDR: begin
                if (done_cnt_q < total_q) begin
                  shift_d = '0;
                  bit_d   = '0;
                  state_d = S_RX_LOW1;
                end else begin
                  state_d = S_STOP_A;
                end
              end
              default: begin
                if (!acked) begin
                  state_d = S_STOP_A;
                end else begin
                  done_cnt_d = done_inc[CntW-1:0];
                  if (done_inc < {1'b0, total_q} && done_inc < MaxCnt) begin
                    shift_d = rd_data;
                    bit_d   = '0;
                    state_d = S_TX_SET;
                  end else begin
                    state_d = S_STOP_A;
                  end
                end
              end
            endcase
          end
        end
        S_RX_LOW1: state_d = S_RX_LOW2;
        S_RX_LOW2: state_d = S_RX_HIGH1;
        S_RX_HIGH1: begin
          shift_d = {shift_q[6:0], item_i.sda_sample};
          bit_d   = bit_inc[3:0];
          if (bit_inc >= 5'(BYTE_BITS)) begin
            res_o.rx_valid = 1'b1;
            res_o.rx_byte  = {shift_q[6:0], item_i.sda_sample};
            res_o.rx_last  = last;
          end
          state_d = S_RX_HIGH2;
        end
        S_RX_HIGH2: state_d = ({1'b0, bit_q} >= 5'(BYTE_BITS)) ? S_MA_SET : S_RX_LOW1;
        S_MA_SET:   state_d = S_MA_HIGH;
        S_MA_HIGH: begin
          done_cnt_d = done_inc[CntW-1:0];
          if (done_inc < {1'b0, total_q}) begin
            shift_d = '0;
            bit_d   = '0;
            state_d = S_RX_LOW1;
          end else begin
            state_d = S_STOP_A;
          end
        end
        S_STOP_A: state_d = S_STOP_B;
        S_STOP_B: state_d = S_STOP_C;
        default: begin
          res_o.done_res = 1'b1;
          res_o.status   = fail_q ? ST_ADDR_NACK : ST_OK;
          if (!is_read_q) begin
            fill_d = '0;
          end
          state_d = S_IDLE;
        end
      endcase
    end

    res_o.scl_release = scl_drv;
    res_o.sda_release = sda_drv;
    res_o.busy_res    = (state_d != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      done_cnt_q <= '0;
      total_q    <= '0;
      wait_q     <= '0;
      addr_q     <= '0;
      reg_q      <= '0;
      is_read_q  <= 1'b0;
      fill_q     <= '0;
      role_q     <= ROLE_WADDR;
      fail_q     <= 1'b0;
    end else if (step_i) begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      done_cnt_q <= done_cnt_d;
      total_q    <= total_d;
      wait_q     <= wait_d;
      addr_q     <= addr_d;
      reg_q      <= reg_d;
      is_read_q  <= is_read_d;
      fill_q     <= fill_d;
      role_q     <= role_d;
      fail_q     <= fail_d;
    end
  end

endmodule

@@ rtl/i2c_master_register_access.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake                   Payload
// s_axis   in   s_axis_tvalid/tready        tdata: command fields, tuser: op
// m_axis   out  m_axis_tvalid/tready        tdata: line drive and status,
//                                           tuser: rx_valid, tlast: rx_last
// cfg      in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One word in, one word out. A word is taken every cycle when the output side
// keeps up; it is held in the input register and its result is captured in the
// output register, which drives m_axis_tvalid.
// The input register is freed whenever the output register is empty or being
// drained, so a stall on m_axis holds at most one word on each side.
// Reset (rst_ni low) returns the sequencer to idle, empties both registers and
// loads phase_ticks = 1, ack_timeout = 50. Config writes are always taken.

module i2c_master_register_access #(
  parameter int unsigned MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] dev_addr, [14:7] reg_addr, [19:15] byte_count, [27:20] tx_byte,
  // [28] sda_sample, [31:29] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_release, [1] sda_release, [9:2] rx_byte, [10] done_res,
  // [12:11] status, [13] busy_res, [15:14] zero
  output logic [15:0] m_axis_tdata,
  // [0] rx_valid
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import i2cm_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res;
  cfg_t    cfg_q;
  logic    step;
  item_t   s_item;

  assign s_item.op         = op_e'(s_axis_tuser);
  assign s_item.dev_addr   = s_axis_tdata[6:0];
  assign s_item.reg_addr   = s_axis_tdata[14:7];
  assign s_item.byte_count = s_axis_tdata[19:15];
  assign s_item.tx_byte    = s_axis_tdata[27:20];
  assign s_item.sda_sample = s_axis_tdata[28];

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks <= PHASE_TICKS_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cm_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_item_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.busy_res, res_q.status, res_q.done_res,
                          res_q.rx_byte, res_q.sda_release, res_q.scl_release};
  assign m_axis_tuser  = res_q.rx_valid;
  assign m_axis_tlast  = res_q.rx_last;

`ifndef SYNTH
  // a finished transaction never reports itself still busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.done_res && res_q.busy_res))
    else $error("done_res with busy_res");

  // status carries meaning only on the done word
  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.done_res) |-> (res_q.status == ST_OK))
    else $error("status without done_res");

  // a received byte always falls inside a running transaction
  a_rx_in_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.rx_valid) |-> (res.busy_res && !res.done_res))
    else $error("rx_valid outside a transaction");

  // a held word in the input register is never dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_item_q)))
    else $error("input word lost");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 200;

  // Expected-word tracker: a word-by-word copy of the bus sequencer, fed with
  // every accepted command word; results are checked in order.
  class i2c_scoreboard;
    logic [7:0] phase_ticks, ack_timeout;
    state_e     seq;
    role_e      role;
    logic [7:0] phase_cnt, shreg, wait_cnt;
    logic [3:0] bit_idx;
    int         n_done, n_total, fill, hi_water;
    logic [6:0] dev;
    logic [7:0] regad;
    bit         rd, failed;
    logic [7:0] wbuf [MAX_BYTES_DEF];
    result_t    expq [$];
    int         n_inputs, n_checked, n_errors, n_rx, n_ok, n_busy, n_nack;

    function new();
      phase_ticks = PHASE_TICKS_RST;
      ack_timeout = ACK_TIMEOUT_RST;
      seq         = S_IDLE;
      role        = ROLE_WADDR;
      phase_cnt   = '0;
      shreg       = '0;
      wait_cnt    = '0;
      bit_idx     = '0;
      n_done      = 0;
      n_total     = 0;
      fill        = 0;
      hi_water    = 0;
      dev         = '0;
      regad       = '0;
      rd          = 1'b0;
      failed      = 1'b0;
      n_inputs    = 0;
      n_checked   = 0;
      n_errors    = 0;
      n_rx        = 0;
      n_ok        = 0;
      n_busy      = 0;
      n_nack      = 0;
    endfunction

    function void set_cfg(logic idx, logic [7:0] val);
      if (idx == CFG_PHASE_TICKS) phase_ticks = val;
      else ack_timeout = val;
    endfunction

    function void load_byte(logic [7:0] val, role_e r);
      shreg   = val;
      role    = r;
      bit_idx = '0;
      seq     = S_TX_SET;
    endfunction

    function void next_data();
      if (n_done < n_total && n_done < MAX_BYTES_DEF) load_byte(wbuf[n_done], ROLE_DATA);
      else seq = S_STOP_A;
    endfunction

    function void next_read();
      if (n_done < n_total) begin
        shreg   = '0;
        bit_idx = '0;
        seq     = S_RX_LOW1;
      end else begin
        seq = S_STOP_A;
      end
    endfunction

    function void on_ack(bit acked);
      case (role)
        ROLE_WADDR: begin
          if (!acked) begin
            failed = 1'b1;
            seq    = S_STOP_A;
          end else begin
            load_byte(regad, ROLE_REG);
          end
        end
        ROLE_REG: begin
          // a missing ack on the register byte is not an error
          if (rd) begin
            role = ROLE_RADDR;
            seq  = S_RS_PREP;
          end else begin
            next_data();
          end
        end
        ROLE_RADDR: next_read();
        default: begin
          if (!acked) begin
            seq = S_STOP_A;
          end else begin
            n_done++;
            next_data();
          end
        end
      endcase
    endfunction

    function void note_input(item_t it);
      result_t r;
      bit      last;
      int      ticks, nxt;
      r             = '0;
      r.status      = ST_OK;
      r.scl_release = 1'b1;
      r.sda_release = 1'b1;
      last          = (n_done + 1) >= n_total;
      case (seq)
        S_START_B: r.sda_release = 1'b0;
        S_RS_PREP, S_ACK_SET, S_RX_LOW1, S_RX_LOW2: r.scl_release = 1'b0;
        S_TX_SET, S_TX_HOLD: begin
          r.scl_release = 1'b0;
          r.sda_release = shreg[7];
        end
        S_TX_HIGH: r.sda_release = shreg[7];
        S_MA_SET: begin
          r.scl_release = 1'b0;
          r.sda_release = last;
        end
        S_MA_HIGH: r.sda_release = last;
        S_STOP_A: begin
          r.scl_release = 1'b0;
          r.sda_release = 1'b0;
        end
        S_STOP_B: r.sda_release = 1'b0;
        default: ;
      endcase

      if (seq == S_IDLE) begin
        if (it.op == OP_PUSH) begin
          if (fill < MAX_BYTES_DEF) begin
            wbuf[fill] = it.tx_byte;
            fill++;
            if (fill > hi_water) hi_water = fill;
          end
        end else if (it.op == OP_WRITE || it.op == OP_READ) begin
          rd = (it.op == OP_READ);
          if (!it.sda_sample) begin
            // line held low by someone else
            r.done_res = 1'b1;
            r.status   = ST_BUS_BUSY;
            n_busy++;
            if (!rd) fill = 0;
          end else begin
            dev       = it.dev_addr;
            regad     = it.reg_addr;
            n_total   = (it.byte_count > MAX_BYTES_DEF) ? MAX_BYTES_DEF : it.byte_count;
            n_done    = 0;
            failed    = 1'b0;
            wait_cnt  = '0;
            role      = ROLE_WADDR;
            phase_cnt = '0;
            seq       = S_START_A;
          end
        end
      end else begin
        ticks = (phase_ticks == 0) ? 1 : phase_ticks;
        if (phase_cnt + 1 < ticks) begin
          phase_cnt++;
        end else begin
          phase_cnt = '0;
          case (seq)
            S_RS_PREP: seq = S_START_A;
            S_START_A: seq = S_START_B;
            S_START_B: load_byte({dev, role == ROLE_RADDR}, role);
            S_TX_SET:  seq = S_TX_HIGH;
            S_TX_HIGH: seq = S_TX_HOLD;
            S_TX_HOLD: begin
              shreg = {shreg[6:0], 1'b0};
              bit_idx++;
              if (bit_idx >= BYTE_BITS) begin
                wait_cnt = '0;
                seq      = S_ACK_SET;
              end else begin
                seq = S_TX_SET;
              end
            end
            S_ACK_SET: seq = S_ACK_WAIT;
            S_ACK_WAIT: begin
              if (!it.sda_sample) begin
                on_ack(1'b1);
              end else begin
                nxt      = wait_cnt + 1;
                wait_cnt = nxt[7:0];
                if (nxt > ack_timeout) on_ack(1'b0);
              end
            end
            S_RX_LOW1: seq = S_RX_LOW2;
            S_RX_LOW2: seq = S_RX_HIGH1;
            S_RX_HIGH1: begin
              shreg = {shreg[6:0], it.sda_sample};
              bit_idx++;
              if (bit_idx >= BYTE_BITS) begin
                r.rx_valid = 1'b1;
                r.rx_byte  = shreg;
                r.rx_last  = last;
                n_rx++;
              end
              seq = S_RX_HIGH2;
            end
            S_RX_HIGH2: seq = (bit_idx >= BYTE_BITS) ? S_MA_SET : S_RX_LOW1;
            S_MA_SET:   seq = S_MA_HIGH;
            S_MA_HIGH: begin
              n_done++;
              next_read();
            end
            S_STOP_A: seq = S_STOP_B;
            S_STOP_B: seq = S_STOP_C;
            default: begin
              // stop complete
              r.done_res = 1'b1;
              r.status   = failed ? ST_ADDR_NACK : ST_OK;
              if (failed) n_nack++;
              else n_ok++;
              if (!rd) fill = 0;
              seq = S_IDLE;
            end
          endcase
        end
      end
      r.busy_res = (seq != S_IDLE);
      expq.push_back(r);
      n_inputs++;
    endfunction

    function string show(result_t r);
      return $sformatf("scl=%0b sda=%0b rx=%02h v=%0b l=%0b done=%0b st=%0d busy=%0b",
                       r.scl_release, r.sda_release, r.rx_byte, r.rx_valid, r.rx_last,
                       r.done_res, r.status, r.busy_res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   bad;
      if (expq.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("tb: unexpected result word: %s", show(got));
        return;
      end
      want = expq.pop_front();
      bad  = "";
      if (got.scl_release !== want.scl_release) bad = {bad, " scl_release"};
      if (got.sda_release !== want.sda_release) bad = {bad, " sda_release"};
      if (got.rx_byte !== want.rx_byte)         bad = {bad, " rx_byte"};
      if (got.rx_valid !== want.rx_valid)       bad = {bad, " rx_valid"};
      if (got.rx_last !== want.rx_last)         bad = {bad, " rx_last"};
      if (got.done_res !== want.done_res)       bad = {bad, " done_res"};
      if (got.status !== want.status)           bad = {bad, " status"};
      if (got.busy_res !== want.busy_res)       bad = {bad, " busy_res"};
      if (bad != "") begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("tb: result %0d mismatch in%s", n_checked, bad);
          $display("tb:   expected %s", show(want));
          $display("tb:   actual   %s", show(got));
        end
      end
      n_checked++;
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [7:0]  cfg_data_i    = '0;

  i2c_scoreboard sb;
  bit            calm;      // both sides run without gaps while set
  bit            ack_miss;  // emulated target withholds the ack for this byte
  bit            held;
  int unsigned   quiet;

  i2c_master_register_access DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic item_t mk(op_e op, logic [6:0] dev, logic [7:0] ra,
                               logic [4:0] cnt, logic [7:0] tx, logic sda);
    item_t it;
    it.op         = op;
    it.dev_addr   = dev;
    it.reg_addr   = ra;
    it.byte_count = cnt;
    it.tx_byte    = tx;
    it.sda_sample = sda;
    return it;
  endfunction

  // Next tick word: acts as a well-behaved target most of the time, with
  // occasional missing acks, bus-busy starts and stray commands.
  function automatic item_t pick_item();
    item_t it;
    int    r, sat;
    it = mk(op_e'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
            8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (sb.seq == S_IDLE) begin
      r = $urandom_range(0, 99);
      it.op = (r < 45) ? OP_PUSH : (r < 67) ? OP_WRITE : (r < 90) ? OP_READ : OP_TICK;
      if (it.op == OP_WRITE || it.op == OP_READ) begin
        it.sda_sample = ($urandom_range(0, 9) != 0);
        // long transfers only at the fastest bit rate
        if (!(sb.phase_ticks <= 1 && $urandom_range(0, 9) == 0))
          it.byte_count = 5'($urandom_range(0, 3));
        sat = (it.byte_count > MAX_BYTES_DEF) ? MAX_BYTES_DEF : it.byte_count;
        // never let a write fetch a buffer entry that was never pushed
        if (it.op == OP_WRITE && it.sda_sample && sat > sb.hi_water)
          it.byte_count = 5'($urandom_range(0, sb.hi_water));
      end
    end else begin
      if ($urandom_range(0, 99) < 85) it.op = OP_TICK;
      if (sb.seq == S_ACK_SET)
        ack_miss = $urandom_range(0, 99) < ((sb.role == ROLE_WADDR) ? 12 : 15);
      else if (sb.seq == S_ACK_WAIT)
        it.sda_sample = ack_miss || ($urandom_range(0, 3) == 0);
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {3'b000, it.sda_sample, it.tx_byte, it.byte_count, it.reg_addr,
                      it.dev_addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic run_to_idle();
    while (sb.seq != S_IDLE) send_item(pick_item());
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_cfg(idx, val);
  endtask

  initial begin
    int    ph_ticks [6] = '{1, 0, 2, 3, 255, 1};
    int    ph_ackto [6] = '{1, 255, 0, 20, 1, 50};
    int    ph_words [6] = '{200, 150, 150, 150, 0, 200};
    item_t it;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle-state corners, bus busy on both begins, then commands while busy
    send_item(mk(OP_TICK, 7'h00, 8'h00, 5'd0, 8'h00, 1'b0));
    send_item(mk(OP_TICK, 7'h7F, 8'hFF, 5'd31, 8'hFF, 1'b1));
    send_item(mk(OP_PUSH, 7'h00, 8'h00, 5'd0, 8'h00, 1'b1));
    send_item(mk(OP_PUSH, 7'h7F, 8'hFF, 5'd31, 8'hFF, 1'b0));
    send_item(mk(OP_PUSH, 7'h2A, 8'h3C, 5'd5, 8'hA5, 1'b1));
    send_item(mk(OP_READ, 7'h55, 8'h0F, 5'd2, 8'h00, 1'b0));
    send_item(mk(OP_WRITE, 7'h2B, 8'hF0, 5'd2, 8'h00, 1'b0));
    send_item(mk(OP_PUSH, 7'h00, 8'h00, 5'd0, 8'h5A, 1'b1));
    // three bytes requested, only the first pushed since the buffer was cleared
    send_item(mk(OP_WRITE, 7'h7F, 8'hFF, 5'd3, 8'h00, 1'b1));
    send_item(mk(OP_PUSH, 7'h00, 8'h00, 5'd0, 8'h33, 1'b1));
    send_item(mk(OP_READ, 7'h00, 8'h00, 5'd31, 8'h00, 1'b1));
    send_item(mk(OP_WRITE, 7'h11, 8'h22, 5'd1, 8'h44, 1'b1));
    send_item(mk(OP_TICK, 7'h7F, 8'hFF, 5'd31, 8'hFF, 1'b1));
    run_to_idle();
    // oversized count saturates
    send_item(mk(OP_READ, 7'h00, 8'h00, 5'd31, 8'h00, 1'b1));
    run_to_idle();

    for (int p = 0; p < 6; p++) begin
      settle();
      write_cfg(CFG_PHASE_TICKS, 8'(ph_ticks[p]));
      write_cfg(CFG_ACK_TIMEOUT, 8'(ph_ackto[p]));
      cfg_valid_i <= 1'b0;
      if (ph_ticks[p] == 255) begin
        // slowest bit rate: one write whose address is never acked
        send_item(mk(OP_WRITE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     5'd0, 8'h00, 1'b1));
        while (sb.seq != S_IDLE) begin
          it = pick_item();
          it.sda_sample = 1'b1;
          send_item(it);
        end
      end else begin
        repeat (ph_words[p]) send_item(pick_item());
        run_to_idle();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("tb: %0d tick words, %0d results checked, %0d bytes read, %0d mismatches",
             sb.n_inputs, sb.n_checked, sb.n_rx, sb.n_errors);
    $display("tb: transactions ok %0d, bus busy %0d, address nack %0d, six rate settings",
             sb.n_ok, sb.n_busy, sb.n_nack);
    if (sb.n_errors == 0 && sb.expq.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // result sink with random back-pressure and one long hold-off
  initial begin
    int      stall;
    result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (!held && sb.n_inputs > 300) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.scl_release = m_axis_tdata[0];
      got.sda_release = m_axis_tdata[1];
      got.rx_byte     = m_axis_tdata[9:2];
      got.rx_valid    = m_axis_tuser;
      got.rx_last     = m_axis_tlast;
      got.done_res    = m_axis_tdata[10];
      got.status      = status_e'(m_axis_tdata[12:11]);
      got.busy_res    = m_axis_tdata[13];
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: no word moved for %0d cycles", quiet);
        $display("tb: done, errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule
